@@ rtl/pedestrian_audio_cue_controller_defines.svh @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller: assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef PEDESTRIAN_AUDIO_CUE_CONTROLLER_DEFINES_SVH
`define PEDESTRIAN_AUDIO_CUE_CONTROLLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PACC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pacc assertion failed");
`define PACC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pacc assertion failed");
`else
`define PACC_ASSERT(lbl, clk, rst_n, prop)
`define PACC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/pacc_pkg.sv @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller package
// Shared widths, character codes, enums and inter-module structs.
// ---------------------------------------------------------------------------
package pacc_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int CFG_W        = 16;
  localparam int CMP_W        = (COUNTER_BITS > CFG_W) ? COUNTER_BITS : CFG_W;
  localparam int CFG_IDX_W    = 1;
  localparam int BYTE_W       = 8;
  localparam int MAG_W        = 10;
  localparam int PROD_W       = 14;
  localparam int SEC_W        = 11;
  localparam int CLIP_W       = 3;

  localparam logic [MAG_W-1:0]        MAG_MAX       = 10'd999;
  localparam logic [CFG_W-1:0]        LOCKOUT_RESET = 16'd4000;
  localparam logic [CFG_W-1:0]        TIMEOUT_RESET = 16'd5000;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX       = {COUNTER_BITS{1'b1}};

  localparam logic [BYTE_W-1:0] CH_G     = 8'h47;
  localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CH_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic {OP_BYTE, OP_TICK} op_t;

  typedef enum logic [CFG_IDX_W-1:0] {REG_LOCKOUT, REG_TIMEOUT} cfg_reg_t;

  typedef enum logic [1:0] {
    COLOR_NONE, COLOR_GREEN, COLOR_YELLOW, COLOR_RED
  } color_t;

  typedef enum logic [1:0] {
    COMMA_NONE, COMMA_AT_START, COMMA_LATER
  } comma_t;

  typedef enum logic [1:0] {
    NUM_BLANKS, NUM_SIGNED, NUM_DIGITS, NUM_DONE
  } num_phase_t;

  typedef enum logic [CLIP_W-1:0] {
    CLIP_NONE, CLIP_WAIT, CLIP_WAIT_TEN, CLIP_WAIT_FIVE, CLIP_OFFLINE, CLIP_CROSS
  } clip_t;

  typedef struct packed {
    logic                    hit;
    color_t                  color;
    logic signed [SEC_W-1:0] seconds;
  } line_event_t;

  typedef struct packed {
    logic  fire;
    clip_t clip;
    logic  send_request;
  } cue_result_t;

endpackage

@@ rtl/pacc_if.sv @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller channel interfaces
// Valid/ready channels for input items and for cue results.
// ---------------------------------------------------------------------------
interface pacc_in_if
  import pacc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;
  logic              button_level;

  modport source (output valid, output op, output rx_byte, output button_level,
                  input ready);
  modport sink (input valid, input op, input rx_byte, input button_level,
                output ready);
endinterface

interface pacc_out_if
  import pacc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CLIP_W-1:0] clip;
  logic              send_request;

  modport source (output valid, output clip, output send_request, input ready);
  modport sink (input valid, input clip, input send_request, output ready);
endinterface

@@ rtl/pacc_line_parser.sv @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller: line parser
// Assembles "color,number" lines from serial characters and flags a valid one.
// ---------------------------------------------------------------------------
module pacc_line_parser
  import pacc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              char_stb,
  input  logic [BYTE_W-1:0] rx_byte,
  output line_event_t       line_evt
);

  logic              nonempty_r, nonempty_nxt;
  logic [BYTE_W-1:0] first_char_r, first_char_nxt;
  comma_t            comma_r, comma_nxt;
  num_phase_t        phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic [MAG_W-1:0]  mag_r, mag_nxt;

  logic              is_blank, is_sign, is_digit;
  logic [PROD_W-1:0] mag_ext, prod;
  color_t            color;
  logic              color_ok;
  logic signed [SEC_W-1:0] mag_signed;

  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

  // digit value is the low nibble of an ASCII digit
  assign mag_ext  = {{(PROD_W-MAG_W){1'b0}}, mag_r};
  assign prod     = (mag_ext << 3) + (mag_ext << 1) + {{(PROD_W-4){1'b0}}, rx_byte[3:0]};

  assign mag_signed = $signed({{(SEC_W-MAG_W){1'b0}}, mag_r});

  always_comb begin
    case (first_char_r)
      CH_G:    color = COLOR_GREEN;
      CH_Y:    color = COLOR_YELLOW;
      CH_R:    color = COLOR_RED;
      default: color = COLOR_NONE;
    endcase
  end

  assign color_ok = (color != COLOR_NONE);

  always_comb begin
    nonempty_nxt   = nonempty_r;
    first_char_nxt = first_char_r;
    comma_nxt      = comma_r;
    phase_nxt      = phase_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    line_evt.hit     = 1'b0;
    line_evt.color   = color;
    line_evt.seconds = neg_r ? -mag_signed : mag_signed;

    if (char_stb && (rx_byte != CH_CR)) begin
      if (rx_byte == CH_LF) begin
        line_evt.hit   = nonempty_r && (comma_r == COMMA_LATER) && color_ok;
        nonempty_nxt   = 1'b0;
        first_char_nxt = '0;
        comma_nxt      = COMMA_NONE;
        phase_nxt      = NUM_BLANKS;
        neg_nxt        = 1'b0;
        mag_nxt        = '0;
      end else if (!nonempty_r) begin
        nonempty_nxt   = 1'b1;
        first_char_nxt = rx_byte;
        if (rx_byte == CH_COMMA) begin
          comma_nxt = COMMA_AT_START;
        end
      end else if (comma_r == COMMA_NONE) begin
        if (rx_byte == CH_COMMA) begin
          comma_nxt = COMMA_LATER;
        end
      end else if ((phase_r == NUM_BLANKS) && is_blank) begin
        phase_nxt = NUM_BLANKS;
      end else if ((phase_r == NUM_BLANKS) && is_sign) begin
        neg_nxt   = (rx_byte == CH_MINUS);
        phase_nxt = NUM_SIGNED;
      end else if (phase_r != NUM_DONE) begin
        if (is_digit) begin
          // saturate the magnitude
          mag_nxt   = (prod > PROD_W'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
          phase_nxt = NUM_DIGITS;
        end else begin
          phase_nxt = NUM_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r   <= 1'b0;
      first_char_r <= '0;
      comma_r      <= COMMA_NONE;
      phase_r      <= NUM_BLANKS;
      neg_r        <= 1'b0;
      mag_r        <= '0;
    end else begin
      nonempty_r   <= nonempty_nxt;
      first_char_r <= first_char_nxt;
      comma_r      <= comma_nxt;
      phase_r      <= phase_nxt;
      neg_r        <= neg_nxt;
      mag_r        <= mag_nxt;
    end
  end

endmodule

@@ rtl/pacc_cue_unit.sv @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller: cue unit
// Keeps light state and ms counters, qualifies presses and picks the clip.
// ---------------------------------------------------------------------------
module pacc_cue_unit
  import pacc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick_stb,
  input  logic             button_level,
  input  line_event_t      line_evt,
  input  logic [CFG_W-1:0] lockout_ms,
  input  logic [CFG_W-1:0] link_limit_ms,
  output cue_result_t      res
);

  color_t                  color_r, color_nxt;
  logic signed [SEC_W-1:0] seconds_r, seconds_nxt;
  logic                    req_sent_r, req_sent_nxt;
  logic                    last_btn_r, last_btn_nxt;
  logic [COUNTER_BITS-1:0] since_press_r, since_press_nxt;
  logic [COUNTER_BITS-1:0] since_packet_r, since_packet_nxt;

  logic [COUNTER_BITS-1:0] press_inc, packet_inc;
  logic                    stale;
  clip_t                   clip;

  assign press_inc  = (since_press_r == CNT_MAX) ? since_press_r : since_press_r + 1'b1;
  assign packet_inc = (since_packet_r == CNT_MAX) ? since_packet_r : since_packet_r + 1'b1;
  assign stale      = CMP_W'(packet_inc) > CMP_W'(link_limit_ms);

  always_comb begin
    if (stale) begin
      clip = CLIP_OFFLINE;
    end else begin
      case (color_r)
        COLOR_RED:    clip = (seconds_r <= 11'sd5) ? CLIP_WAIT : CLIP_CROSS;
        COLOR_YELLOW: clip = CLIP_WAIT;
        COLOR_GREEN: begin
          if (seconds_r == 11'sd10) begin
            clip = CLIP_WAIT_TEN;
          end else if (seconds_r == 11'sd5) begin
            clip = CLIP_WAIT_FIVE;
          end else if ((seconds_r >= 11'sd1) && (seconds_r <= 11'sd9)) begin
            clip = CLIP_WAIT;
          end else begin
            clip = CLIP_WAIT_TEN;
          end
        end
        default:      clip = CLIP_NONE;
      endcase
    end
  end

  always_comb begin
    color_nxt        = color_r;
    seconds_nxt      = seconds_r;
    req_sent_nxt     = req_sent_r;
    last_btn_nxt     = last_btn_r;
    since_press_nxt  = since_press_r;
    since_packet_nxt = since_packet_r;
    res.fire         = 1'b0;
    res.clip         = clip;
    res.send_request = 1'b0;

    if (line_evt.hit) begin
      color_nxt        = line_evt.color;
      seconds_nxt      = line_evt.seconds;
      since_packet_nxt = '0;
      if (line_evt.color == COLOR_RED) begin
        req_sent_nxt = 1'b0;
      end
    end

    if (tick_stb) begin
      last_btn_nxt     = button_level;
      since_packet_nxt = packet_inc;
      res.fire         = last_btn_r && !button_level &&
                         (CMP_W'(press_inc) >= CMP_W'(lockout_ms));
      since_press_nxt  = res.fire ? '0 : press_inc;
      // one request per green or yellow phase
      res.send_request = res.fire && !req_sent_r &&
                         ((color_r == COLOR_GREEN) || (color_r == COLOR_YELLOW));
      if (res.send_request) begin
        req_sent_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r        <= COLOR_NONE;
      seconds_r      <= '0;
      req_sent_r     <= 1'b0;
      last_btn_r     <= 1'b1;
      since_press_r  <= '0;
      since_packet_r <= '0;
    end else begin
      color_r        <= color_nxt;
      seconds_r      <= seconds_nxt;
      req_sent_r     <= req_sent_nxt;
      last_btn_r     <= last_btn_nxt;
      since_press_r  <= since_press_nxt;
      since_packet_r <= since_packet_nxt;
    end
  end

endmodule

@@ rtl/pedestrian_audio_cue_controller.sv @@
// ---------------------------------------------------------------------------
// Pedestrian audio cue controller
// Turns light status lines and button ticks into audio cue results.
// ---------------------------------------------------------------------------
// Input channel in_ch carries one item per beat: a serial character (op 0)
// or a one-millisecond tick with the button level (op 1). Output channel
// out_ch carries one cue beat (clip, send_request) per accepted button press;
// characters and other ticks produce nothing.
// An item is captured in an input register, then processed into the result
// register: a cue is offered on out_ch once its tick has left the input register.
// One item per cycle is sustained while out_ch does not stall; the line and
// light state are updated as each item leaves the input register.
// When out_ch stalls with a cue pending, the input register still takes one
// more item, then in_ch.ready drops until the cue is taken.
// cfg_we writes the press lockout (index 0) or the link timeout (index 1);
// write only while the block is idle. Synchronous reset (rst_n low) empties
// both registers, clears light state and line assembly, and loads lockout
// 4000 ms and timeout 5000 ms.
// ---------------------------------------------------------------------------
`include "pedestrian_audio_cue_controller_defines.svh"

module pedestrian_audio_cue_controller
  import pacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pacc_in_if.sink              in_ch,
  pacc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_btn_r;

  logic              out_valid_r;
  clip_t             out_clip_r;
  logic              out_req_r;

  logic [CFG_W-1:0]  lockout_r, timeout_r;

  logic              advance;
  logic              in_take;
  logic              char_stb;
  logic              tick_stb;
  logic              out_held;
  line_event_t       line_evt;
  cue_result_t       res;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign char_stb    = advance && (s1_op_r == OP_BYTE);
  assign tick_stb    = advance && (s1_op_r == OP_TICK);
  assign out_held    = out_valid_r && !out_ch.ready;

  pacc_line_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .char_stb (char_stb),
    .rx_byte  (s1_byte_r),
    .line_evt (line_evt)
  );

  pacc_cue_unit u_cue (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_stb      (tick_stb),
    .button_level  (s1_btn_r),
    .line_evt      (line_evt),
    .lockout_ms    (lockout_r),
    .link_limit_ms (timeout_r),
    .res           (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= op_t'(in_ch.op);
      s1_byte_r <= in_ch.rx_byte;
      s1_btn_r  <= in_ch.button_level;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.fire;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_clip_r <= res.clip;
      out_req_r  <= res.send_request;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.clip         = out_clip_r;
  assign out_ch.send_request = out_req_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r <= LOCKOUT_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOCKOUT: lockout_r <= cfg_wdata;
        REG_TIMEOUT: timeout_r <= cfg_wdata;
        default:     lockout_r <= lockout_r;
      endcase
    end
  end

  `PACC_ASSERT(a_stall_only_when_full, clk, rst_n, !in_ch.ready |-> (s1_valid_r && out_held))
  `PACC_ASSERT(a_char_gives_no_cue, clk, rst_n, char_stb |=> !out_valid_r)
  `PACC_ASSERT(a_drained_when_empty, clk, rst_n, (!s1_valid_r && out_ch.ready) |=> !out_valid_r)
  `PACC_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!out_valid_r && !s1_valid_r))

endmodule

@@ sim/pacc_cue_checker.sv @@
// ----------------------------------------------------------------------------
// Pedestrian audio cue controller: cue checker
// Watches both channels and the register port, keeps its own copy of the
// light, line and press state, predicts the cue for every accepted press and
// compares each cue beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module pacc_cue_checker
  import pacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  pacc_in_if                   in_mon,
  pacc_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   cues_pending,
  output int                   cues_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies
  logic [CFG_W-1:0] lockout_lim;
  logic [CFG_W-1:0] timeout_lim;

  // Light and press state
  color_t                  lt_color;
  logic signed [SEC_W-1:0] lt_seconds;
  logic                    req_latched;
  logic                    btn_prev;
  logic [COUNTER_BITS-1:0] press_age;
  logic [COUNTER_BITS-1:0] packet_age;

  // Line assembly
  logic              ln_open;
  logic [BYTE_W-1:0] ln_head;
  comma_t            ln_comma;
  num_phase_t        num_phase;
  logic              num_neg;
  logic [MAG_W-1:0]  num_mag;

  cue_result_t pending_cues[$];
  int          errs    = 0;
  int          checked = 0;

  initial begin
    fail_count   = 0;
    cues_pending = 0;
    cues_checked = 0;
  end

  task automatic clear_line();
    ln_open   = 1'b0;
    ln_head   = '0;
    ln_comma  = COMMA_NONE;
    num_phase = NUM_BLANKS;
    num_neg   = 1'b0;
    num_mag   = '0;
  endtask

  task automatic predict_cue(input op_t op, input logic [BYTE_W-1:0] ch, input logic lvl,
                             output logic fire, output cue_result_t cue);
    logic blank;
    logic falling;
    int   m;
    int   secs;
    fire  = 1'b0;
    cue   = '0;
    blank = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT) || (ch == CH_FF);
    if (op == OP_BYTE) begin
      if (ch == CH_CR) begin
        // carriage return is dropped entirely
      end else if (ch == CH_LF) begin
        if (ln_open && ln_comma == COMMA_LATER &&
            (ln_head == CH_G || ln_head == CH_Y || ln_head == CH_R)) begin
          lt_color   = (ln_head == CH_G) ? COLOR_GREEN :
                       (ln_head == CH_Y) ? COLOR_YELLOW : COLOR_RED;
          lt_seconds = num_neg ? -$signed({1'b0, num_mag}) : $signed({1'b0, num_mag});
          packet_age = '0;
          if (lt_color == COLOR_RED) begin
            req_latched = 1'b0;
          end
        end
        clear_line();
      end else if (!ln_open) begin
        ln_open = 1'b1;
        ln_head = ch;
        if (ch == CH_COMMA) begin
          ln_comma = COMMA_AT_START;
        end
      end else if (ln_comma == COMMA_NONE) begin
        if (ch == CH_COMMA) begin
          ln_comma = COMMA_LATER;
        end
      end else if (num_phase == NUM_BLANKS && blank) begin
        // skip leading blanks
      end else if (num_phase == NUM_BLANKS && (ch == CH_PLUS || ch == CH_MINUS)) begin
        num_neg   = (ch == CH_MINUS);
        num_phase = NUM_SIGNED;
      end else if (num_phase != NUM_DONE) begin
        if (ch >= CH_ZERO && ch <= CH_NINE) begin
          m         = int'(num_mag) * 10 + (int'(ch) - int'(CH_ZERO));
          num_mag   = (m > int'(MAG_MAX)) ? MAG_MAX : m[MAG_W-1:0];
          num_phase = NUM_DIGITS;
        end else begin
          num_phase = NUM_DONE;
        end
      end
    end else begin
      if (press_age != CNT_MAX) begin
        press_age = press_age + 1'b1;
      end
      if (packet_age != CNT_MAX) begin
        packet_age = packet_age + 1'b1;
      end
      falling  = btn_prev && !lvl;
      btn_prev = lvl;
      if (falling && press_age >= lockout_lim) begin
        press_age = '0;
        fire      = 1'b1;
        cue.fire  = 1'b1;
        secs      = lt_seconds;
        if (packet_age > timeout_lim) begin
          cue.clip = CLIP_OFFLINE;
        end else begin
          case (lt_color)
            COLOR_RED:    cue.clip = (secs <= 5) ? CLIP_WAIT : CLIP_CROSS;
            COLOR_YELLOW: cue.clip = CLIP_WAIT;
            COLOR_GREEN: begin
              if (secs == 10) cue.clip = CLIP_WAIT_TEN;
              else if (secs == 5) cue.clip = CLIP_WAIT_FIVE;
              else if (secs >= 1 && secs <= 9) cue.clip = CLIP_WAIT;
              else cue.clip = CLIP_WAIT_TEN;
            end
            default:      cue.clip = CLIP_NONE;
          endcase
        end
        // one request per green or yellow phase
        if ((lt_color == COLOR_GREEN || lt_color == COLOR_YELLOW) && !req_latched) begin
          req_latched      = 1'b1;
          cue.send_request = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    logic        fire;
    cue_result_t cue;
    cue_result_t due;
    if (!rst_n) begin
      lockout_lim = LOCKOUT_RESET;
      timeout_lim = TIMEOUT_RESET;
      lt_color    = COLOR_NONE;
      lt_seconds  = '0;
      req_latched = 1'b0;
      btn_prev    = 1'b1;
      press_age   = '0;
      packet_age  = '0;
      clear_line();
      pending_cues.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LOCKOUT: lockout_lim = cfg_wdata;
          REG_TIMEOUT: timeout_lim = cfg_wdata;
          default: ;
        endcase
      end
      // compare before predicting so a beat never meets its own tick
      if (out_mon.valid && out_mon.ready) begin
        if (pending_cues.size() == 0) begin
          $error("unexpected cue beat: clip %0d send_request %0d",
                 out_mon.clip, out_mon.send_request);
          errs++;
        end else begin
          due = pending_cues.pop_front();
          if (out_mon.clip !== due.clip) begin
            $error("clip: expected %0d, actual %0d", due.clip, out_mon.clip);
            errs++;
          end
          if (out_mon.send_request !== due.send_request) begin
            $error("send_request: expected %0d, actual %0d",
                   due.send_request, out_mon.send_request);
            errs++;
          end
          checked++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_cue(op_t'(in_mon.op), in_mon.rx_byte, in_mon.button_level, fire, cue);
        if (fire) begin
          pending_cues.push_back(cue);
        end
      end
    end
    fail_count   <= errs;
    cues_pending <= pending_cues.size();
    cues_checked <= checked;
  end

endmodule

@@ sim/tb_pedestrian_audio_cue_controller.sv @@
// ----------------------------------------------------------------------------
// Pedestrian audio cue controller testbench
// Drives status lines, button ticks and noise bytes into the block under
// several lockout and timeout settings and idle patterns, including a long
// output stall; the cue checker judges every result.
// ----------------------------------------------------------------------------
module tb_pedestrian_audio_cue_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import pacc_pkg::*;

  localparam int CYCLE_LIMIT     = 200_000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int ITEMS_PER_PHASE = 350;
  localparam int HOLD_CYCLES     = 300;

  localparam int IDLE_PCT  [4] = '{0, 78, 0, 15};
  localparam int STALL_PCT [4] = '{0, 0, 78, 15};
  localparam int LOCKOUT_SET [4] = '{2, 0, 5, 1};
  localparam int TIMEOUT_SET [4] = '{20, 0, 12, 40};

  logic clk = 1'b0;
  logic rst_n;

  pacc_in_if  in_ch();
  pacc_out_if out_ch();

  logic             cfg_we;
  cfg_reg_t         cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold_left   = 0;
  int beats_sent     = 0;
  int settings_used  = 0;
  int cycles_run     = 0;
  int fail_count;
  int cues_pending;
  int cues_checked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pedestrian_audio_cue_controller i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pacc_cue_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .cues_pending (cues_pending),
    .cues_checked (cues_checked)
  );

  // Valid stays high after a beat; the next call either lowers it or reloads it.
  task automatic send_item(input op_t op, input logic [BYTE_W-1:0] ch, input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.rx_byte      <= ch;
    in_ch.button_level <= lvl;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] ch);
    send_item(OP_BYTE, ch, 1'($urandom));
  endtask

  task automatic send_tick(input logic lvl);
    send_item(OP_TICK, 8'($urandom), lvl);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender until every predicted cue is out, then let the pipe empty.
  task automatic drain_cues();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cues_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_limits(input logic [CFG_W-1:0] lockout,
                                input logic [CFG_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOCKOUT;
    cfg_wdata <= lockout;
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic send_status_line();
    logic [BYTE_W-1:0] head;
    string             digits;
    int                pick;
    int                secs;
    pick = $urandom_range(99);
    case ($urandom_range(2))
      0:       head = CH_G;
      1:       head = CH_Y;
      default: head = CH_R;
    endcase
    if (pick >= 88) head = (pick < 93) ? CH_COMMA : 8'($urandom_range(32, 126));
    send_byte(head);
    if ($urandom_range(9) == 0) send_byte(8'($urandom_range(32, 126)));
    if ($urandom_range(19) != 0) send_byte(CH_COMMA);
    repeat ((($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)) begin
      case ($urandom_range(3))
        0:       send_byte(CH_SPACE);
        1:       send_byte(CH_TAB);
        2:       send_byte(CH_VT);
        default: send_byte(CH_FF);
      endcase
    end
    case ($urandom_range(5))
      0:       send_byte(CH_PLUS);
      1:       send_byte(CH_MINUS);
      default: ;
    endcase
    // mostly values around the five and ten second thresholds
    pick = $urandom_range(9);
    secs = (pick < 7) ? $urandom_range(12) : (pick < 9) ? $urandom_range(2000) : -1;
    if (secs >= 0) begin
      digits = $sformatf("%0d", secs);
      if ($urandom_range(4) == 0) digits = {"0", digits};
      for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
    end
    if ($urandom_range(7) == 0) begin
      send_byte(8'($urandom_range(33, 126)));
      send_byte(CH_ZERO + 8'($urandom_range(9)));
    end
    if ($urandom_range(4) == 0) send_byte(CH_CR);
    if ($urandom_range(24) != 0) send_byte(CH_LF);
  endtask

  task automatic run_mixed_traffic(input int n);
    int stop_at;
    int pick;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 40) send_status_line();
      else if (pick < 85) repeat ($urandom_range(1, 12)) send_tick(1'($urandom));
      else if (pick < 95) repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      else send_byte($urandom_range(1) ? CH_CR : CH_LF);
    end
  endtask

  // Output side: random stalls, or a counted hold-off when one is requested.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $error("cycle limit reached with %0d cues outstanding", cues_pending);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_LOCKOUT;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_BYTE;
    in_ch.rx_byte      <= '0;
    in_ch.button_level <= 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines and presses
    program_limits(16'd0, 16'd3);
    send_tick(1'b1);
    send_tick(1'b0);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // bare minus sign: no digits reads as zero seconds
    send_text("G,");
    send_byte(CH_FF);
    send_text("-\n");
    send_tick(1'b1);
    send_tick(1'b0);
    send_text(",R1\n");
    send_byte(8'hFF);
    send_text(",9\n");
    // blanks, plus sign, saturating magnitude cut short by a NUL byte
    send_text("R,");
    send_byte(CH_VT);
    send_byte(CH_TAB);
    send_text("+1234");
    send_byte(8'h00);
    send_byte(CH_LF);
    send_tick(1'b1);
    send_tick(1'b0);
    // let the yellow packet age past the timeout before pressing
    send_text("Y,7\r\n");
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    drain_cues();

    for (int ph = 0; ph < 4; ph++) begin
      program_limits(16'(LOCKOUT_SET[ph]), 16'(TIMEOUT_SET[ph]));
      send_idle_pct  = IDLE_PCT[ph];
      recv_stall_pct = STALL_PCT[ph];
      run_mixed_traffic(ITEMS_PER_PHASE);
      drain_cues();
      if (ph == 0) begin
        // long output hold-off while presses keep coming: fills the block
        program_limits(16'd0, 16'd100);
        rx_hold_left = HOLD_CYCLES;
        repeat (40) begin
          send_tick(1'b1);
          send_tick(1'b0);
        end
        drain_cues();
      end
    end

    $display("Sent %0d input beats under %0d register settings; %0d cue beats checked.",
             beats_sent, settings_used, cues_checked);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pacc_pkg.sv
rtl/pacc_if.sv
rtl/pacc_line_parser.sv
rtl/pacc_cue_unit.sv
rtl/pedestrian_audio_cue_controller.sv
sim/pacc_cue_checker.sv
sim/tb_pedestrian_audio_cue_controller.sv
